// ===== sv/pai_pkg.sv =====
package pai_pkg;

  localparam int MAX_BATCH   = 4;
  localparam int MAX_GRID    = 4;
  localparam int MAT_WORDS   = 12;
  localparam int SUB_CELLS   = 6;
  localparam int TABLE_DEPTH = MAX_BATCH * MAT_WORDS * SUB_CELLS * MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CELL_W      = $clog2(SUB_CELLS * MAX_GRID * MAX_GRID * MAX_GRID + 16);
  localparam int LOC_W       = 38;

  localparam logic signed [LOC_W-1:0] Q_ONE = LOC_W'(65536);

  // Register indexes
  localparam logic [7:0] REG_STEPS  = 8'd0;
  localparam logic [7:0] REG_GRID_X = 8'd1;
  localparam logic [7:0] REG_GRID_Y = 8'd2;
  localparam logic [7:0] REG_GRID_Z = 8'd3;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  typedef struct packed {
    logic [2:0] gx;
    logic [2:0] gy;
    logic [2:0] gz;
  } grid_t;

  typedef struct packed {
    logic [1:0]              bin;
    logic signed [LOC_W-1:0] loc;
  } axis_t;

  // Map a grid register to its effective cell count
  function automatic logic [2:0] eff_grid(input logic [2:0] g);
    if (g == 3'd0) return 3'd1;
    if (g > 3'(MAX_GRID)) return 3'(MAX_GRID);
    return g;
  endfunction

  // Clamped floor cell along one axis and the local coordinate in it
  function automatic axis_t axis_cell(input logic signed [31:0] v, input logic [2:0] n);
    logic signed [LOC_W-1:0] s;
    logic signed [LOC_W-1:0] fl;
    logic [1:0]              c;
    axis_t                   r;
    s  = LOC_W'(v) * $signed({{(LOC_W-3){1'b0}}, n});
    fl = s >>> 16;
    if (s < 0) c = 2'd0;
    else if (fl > $signed(LOC_W'(n) - LOC_W'(1))) c = 2'(n - 3'd1);
    else c = fl[1:0];
    r.bin = c;
    r.loc = s - $signed({{(LOC_W-18){1'b0}}, c, 16'h0000});
    return r;
  endfunction

endpackage

// ===== sv/pai_cell.sv =====
module pai_cell
  import pai_pkg::*;
(
  input  logic                clk,
  input  logic signed [31:0]  px,
  input  logic signed [31:0]  py,
  input  logic signed [31:0]  pz,
  input  grid_t               grid,
  output logic [CELL_W-1:0]   mat_sel
);

  axis_t ax, ay, az;
  logic [5:0] lin;
  logic [CELL_W-1:0] sub;
  logic signed [LOC_W-1:0] x, y, z;

  // Stage one: cell per axis and local coordinates
  always_ff @(posedge clk) begin
    ax <= axis_cell(px, grid.gx);
    ay <= axis_cell(py, grid.gy);
    az <= axis_cell(pz, grid.gz);
  end

  assign x = ax.loc;
  assign y = ay.loc;
  assign z = az.loc;

  // Stage two: linear cell and summed sub-cell offsets
  always_comb begin
    lin = 6'(ax.bin) + 6'(ay.bin) * 6'(grid.gx) + 6'(az.bin) * 6'(grid.gx) * 6'(grid.gy);
    sub = '0;
    if (x <= y && Q_ONE - x > y && x < z && Q_ONE - x >= z) sub = sub + CELL_W'(0);
    if (x > y && x <= Q_ONE - y && y < z && Q_ONE - y >= z) sub = sub + CELL_W'(1);
    if (x >= z && x < Q_ONE - z && y >= z && y < Q_ONE - z) sub = sub + CELL_W'(2);
    if (x <= z && x > Q_ONE - z && y <= z && y > Q_ONE - z) sub = sub + CELL_W'(3);
    if (x < y && x >= Q_ONE - y && y > z && Q_ONE - y <= z) sub = sub + CELL_W'(4);
    if (x >= y && Q_ONE - x < y && x > z && Q_ONE - x <= z) sub = sub + CELL_W'(5);
  end

  always_ff @(posedge clk) begin
    mat_sel <= CELL_W'(SUB_CELLS) * CELL_W'(lin) + sub;
  end

endmodule

// ===== sv/piecewise_affine_point_integrator.sv =====
// Channel  | handshake               | payload
// in       | in_valid / in_ready     | func, table_addr, table_word, batch, in_x, in_y, in_z
// out      | out_valid / out_ready   | out_x, out_y, out_z
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
// A table write is stored as it is accepted. A point runs step_count steps and is then
// loaded into the output register: each step locates the cell (S_LOC, S_IDX), makes twelve reads
// of the single table read port, runs a multiply/accumulate tail and makes one update.
// Reset clears control state and sets the configuration registers to one; the table holds garbage until written.
// A finished point waits in the output register while the next item is accepted.
module piecewise_affine_point_integrator
  import pai_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [14:0]         table_addr,
  input  logic signed [31:0]  table_word,
  input  logic [1:0]          batch,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOC  = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_MAT  = 3'd3;
  localparam logic [2:0] S_NEXT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [7:0] step_count, step;
  logic [2:0] grid_x, grid_y, grid_z;
  grid_t grid;
  logic signed [31:0] p_x, p_y, p_z, n_x, n_y, n_z;
  logic [ADDR_W-1:0] base;
  logic [CELL_W-1:0] mat_sel;
  logic [3:0] rd_k, d1_k, t_k;
  logic d1_v, d1_oor, t_v;
  logic [ADDR_W:0] rd_addr;
  logic rd_en;
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] mem_q;
  logic signed [31:0] word, pcol;
  logic signed [48:0] term;
  logic signed [49:0] acc, sum;
  logic signed [31:0] sat;
  logic in_acc;

  assign grid.gx = eff_grid(grid_x);
  assign grid.gy = eff_grid(grid_y);
  assign grid.gz = eff_grid(grid_z);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= 8'd1;
      grid_x <= 3'd1;
      grid_y <= 3'd1;
      grid_z <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEPS:  step_count <= cfg_data;
        REG_GRID_X: grid_x <= cfg_data[2:0];
        REG_GRID_Y: grid_y <= cfg_data[2:0];
        REG_GRID_Z: grid_z <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  pai_cell u_cell (
    .clk     (clk),
    .px      (p_x),
    .py      (p_y),
    .pz      (p_z),
    .grid    (grid),
    .mat_sel (mat_sel)
  );

  // Table address of the next matrix word
  assign rd_addr = (ADDR_W+1)'(base) + (ADDR_W+1)'(MAT_WORDS) * (ADDR_W+1)'(mat_sel)
                 + (ADDR_W+1)'(rd_k);
  assign rd_en   = (state == S_MAT) && (rd_k < 4'(MAT_WORDS));

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && func == FUNC_WRITE && 32'(table_addr) < 32'(TABLE_DEPTH))
      mem[table_addr[ADDR_W-1:0]] <= table_word;
    if (rd_en && rd_addr < (ADDR_W+1)'(TABLE_DEPTH))
      mem_q <= mem[rd_addr[ADDR_W-1:0]];
  end

  // Multiply stage
  assign word = d1_oor ? 32'sd0 : $signed(mem_q);
  always_comb begin
    case (d1_k[1:0])
      2'd0: pcol = p_x;
      2'd1: pcol = p_y;
      default: pcol = p_z;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d1_k[1:0] == 2'd3) term <= 49'(word);
    else term <= 49'((64'(word) * 64'(pcol)) >>> 16);
  end

  // Accumulate and saturate
  assign sum = acc + 50'(term);
  assign sat = (sum > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
               (sum < -50'sh80000000) ? -32'sh80000000 : sum[31:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      d1_v <= 1'b0;
      t_v <= 1'b0;
      out_valid <= 1'b0;
      rd_k <= '0;
      step <= '0;
      acc <= '0;
    end else begin
      d1_v   <= rd_en;
      d1_k   <= rd_k;
      d1_oor <= rd_addr >= (ADDR_W+1)'(TABLE_DEPTH);
      t_v    <= d1_v;
      t_k    <= d1_k;
      if (t_v) begin
        if (t_k[1:0] == 2'd3) begin
          acc <= '0;
          case (t_k[3:2])
            2'd0: n_x <= sat;
            2'd1: n_y <= sat;
            default: n_z <= sat;
          endcase
        end else begin
          acc <= sum;
        end
      end
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc && func == FUNC_POINT) begin
            p_x <= in_x;
            p_y <= in_y;
            p_z <= in_z;
            base <= ADDR_W'(batch) * ADDR_W'(MAT_WORDS * SUB_CELLS)
                  * ADDR_W'(grid.gx) * ADDR_W'(grid.gy) * ADDR_W'(grid.gz);
            step <= '0;
            state <= (step_count == 8'd0) ? S_DONE : S_LOC;
          end
        end
        S_LOC: begin
          rd_k <= '0;
          state <= S_IDX;
        end
        S_IDX: state <= S_MAT;
        S_MAT: begin
          if (rd_en) rd_k <= rd_k + 4'd1;
          if (t_v && t_k == 4'(MAT_WORDS - 1)) state <= S_NEXT;
        end
        S_NEXT: begin
          p_x <= n_x;
          p_y <= n_y;
          p_z <= n_z;
          step <= step + 8'd1;
          state <= (step + 8'd1 == step_count) ? S_DONE : S_LOC;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_x <= p_x;
            out_y <= p_y;
            out_z <= p_z;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MAT |-> rd_k <= 4'(MAT_WORDS)) else $error("read counter overrun");
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    t_v |-> t_k < 4'(MAT_WORDS)) else $error("accumulate index overrun");
  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && func == FUNC_POINT |=> state != S_IDLE) else $error("point dropped");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_NEXT |-> step < step_count) else $error("step overrun");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import pai_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCHDOG_CYCLES = 20000;
  localparam int  MAX_SHOWN       = 10;
  localparam int  LOW_WORDS       = MAX_BATCH * MAT_WORDS * SUB_CELLS;
  localparam logic [7:0] REG_BAD  = 8'd200;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               func;
  logic [14:0]        table_addr;
  logic signed [31:0] table_word;
  logic [1:0]         batch;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [7:0]         cfg_data;

  // Mirror of the block's table and registers
  logic signed [31:0] matrix_mem [TABLE_DEPTH];
  bit                 written_mem [TABLE_DEPTH];
  logic [7:0]         steps_reg;
  logic [2:0]         gx_reg;
  logic [2:0]         gy_reg;
  logic [2:0]         gz_reg;

  point_t pending_points[$];
  int     mismatches;
  int     points_sent;
  int     writes_sent;
  int     points_checked;
  int     quiet_cycles;
  int     stall_left;
  bit     no_idle;

  piecewise_affine_point_integrator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .table_addr(table_addr), .table_word(table_word), .batch(batch),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic longint eff_cells(logic [2:0] g);
    if (g == 3'd0) return 1;
    if (g > 3'(MAX_GRID)) return MAX_GRID;
    return longint'(g);
  endfunction

  function automatic longint sat_q32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint clamp_axis(longint v, longint n, output longint loc);
    longint s;
    longint c;
    s = v * n;
    c = (s < 0) ? 0 : (s >>> 16);
    if (c > n - 1) c = n - 1;
    loc = s - c * 65536;
    return c;
  endfunction

  function automatic longint matrix_at(longint addr);
    if (addr < 0 || addr >= TABLE_DEPTH) return 0;
    return longint'(matrix_mem[addr]);
  endfunction

  // Move a point through steps_reg piecewise-affine steps; report the first unwritten word
  function automatic point_t integrate_point(logic [1:0] b, point_t start,
                                             output longint missing);
    longint p[3];
    longint np[3];
    longint gx, gy, gz, base, cx, cy, cz, lx, ly, lz, idx, row, one;
    point_t res;
    one = 65536;
    missing = -1;
    gx = eff_cells(gx_reg);
    gy = eff_cells(gy_reg);
    gz = eff_cells(gz_reg);
    base = longint'(b) * MAT_WORDS * SUB_CELLS * gx * gy * gz;
    p[0] = start.x;
    p[1] = start.y;
    p[2] = start.z;
    for (int n = 0; n < steps_reg; n++) begin
      cx = clamp_axis(p[0], gx, lx);
      cy = clamp_axis(p[1], gy, ly);
      cz = clamp_axis(p[2], gz, lz);
      idx = SUB_CELLS * (cx + cy * gx + cz * gx * gy);
      // every sub-cell test that holds adds its offset
      if (lx <= ly && one - lx > ly && lx < lz && one - lx >= lz) idx += 0;
      if (lx > ly && lx <= one - ly && ly < lz && one - ly >= lz) idx += 1;
      if (lx >= lz && lx < one - lz && ly >= lz && ly < one - lz) idx += 2;
      if (lx <= lz && lx > one - lz && ly <= lz && ly > one - lz) idx += 3;
      if (lx < ly && lx >= one - ly && ly > lz && one - ly <= lz) idx += 4;
      if (lx >= ly && one - lx < ly && lx > lz && one - lx <= lz) idx += 5;
      for (int r = 0; r < 3; r++) begin
        row = base + MAT_WORDS * idx + 4 * r;
        for (int k = 0; k < 4; k++)
          if (missing < 0 && row + k < TABLE_DEPTH && !written_mem[row + k])
            missing = row + k;
        np[r] = sat_q32(((matrix_at(row) * p[0]) >>> 16)
                      + ((matrix_at(row + 1) * p[1]) >>> 16)
                      + ((matrix_at(row + 2) * p[2]) >>> 16)
                      + matrix_at(row + 3));
      end
      p = np;
    end
    res.x = p[0][31:0];
    res.y = p[1][31:0];
    res.z = p[2][31:0];
    return res;
  endfunction

  // Send one item; update the mirror and queue the expected point on acceptance
  task automatic send_item(logic f, logic [14:0] addr, logic signed [31:0] word,
                           logic [1:0] b, point_t pt);
    int gap;
    longint miss;
    point_t exp_pt;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    table_addr <= addr;
    table_word <= word;
    batch      <= b;
    in_x       <= pt.x;
    in_y       <= pt.y;
    in_z       <= pt.z;
    do @(posedge clk); while (!in_ready);
    if (f == FUNC_POINT) begin
      exp_pt = integrate_point(b, pt, miss);
      pending_points.push_back(exp_pt);
      points_sent++;
    end else begin
      if (addr < TABLE_DEPTH) begin
        matrix_mem[addr] = word;
        written_mem[addr] = 1'b1;
      end
      writes_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] index, logic [7:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_STEPS:  steps_reg = data;
      REG_GRID_X: gx_reg = data[2:0];
      REG_GRID_Y: gy_reg = data[2:0];
      REG_GRID_Z: gz_reg = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [7:0] gx, logic [7:0] gy, logic [7:0] gz, logic [7:0] st);
    write_reg(REG_GRID_X, gx);
    write_reg(REG_GRID_Y, gy);
    write_reg(REG_GRID_Z, gz);
    write_reg(REG_STEPS, st);
  endtask

  function automatic point_t rand_fields();
    point_t pt;
    pt.x = $urandom();
    pt.y = $urandom();
    pt.z = $urandom();
    return pt;
  endfunction

  // Matrix words: mostly mild contractions, now and then a full-range word
  function automatic logic signed [31:0] matrix_word(int k);
    if ($urandom_range(0, 19) == 0) return $urandom();
    if (k % 4 == 3) return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
    return $signed($urandom_range(0, 32'h10000)) - 32'sh8000;
  endfunction

  // Coordinates: mostly near the unit cube, sometimes cell edges or any value
  function automatic logic signed [31:0] coord(longint g);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, int'(g)) * 65536 / g));
      default: return $signed($urandom_range(0, 32'h18000)) - 32'sh4000;
    endcase
  endfunction

  // Write every table word the point will read that is not yet written, then send the point
  task automatic send_point(logic [1:0] b, point_t pt);
    longint miss;
    void'(integrate_point(b, pt, miss));
    while (miss >= 0) begin
      send_item(FUNC_WRITE, 15'(miss), matrix_word(int'(miss % 12)), 2'($urandom()),
                rand_fields());
      void'(integrate_point(b, pt, miss));
    end
    send_item(FUNC_POINT, 15'($urandom()), $urandom(), b, pt);
  endtask

  task automatic send_random(int count, int max_batch);
    point_t pt;
    longint g;
    g = eff_cells(gx_reg);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: send_item(FUNC_WRITE, 15'($urandom_range(TABLE_DEPTH, 32767)), $urandom(),
                     2'($urandom()), rand_fields());
        1: begin
          int a;
          a = $urandom_range(0, LOW_WORDS - 1);
          send_item(FUNC_WRITE, 15'(a), matrix_word(a % 12), 2'($urandom()), rand_fields());
        end
        default: begin
          pt.x = coord(g);
          pt.y = coord(eff_cells(gy_reg));
          pt.z = coord(eff_cells(gz_reg));
          send_point(2'($urandom_range(0, max_batch)), pt);
        end
      endcase
    end
  endtask

  task automatic test_directed();
    logic signed [31:0] edges [8];
    point_t pt;
    edges = '{32'sh0, 32'sh8000, 32'shFFFF, 32'sh10000, -32'sh1,
              32'sh7FFFFFFF, 32'sh80000000, 32'sh4000};
    set_grid(8'd1, 8'd1, 8'd1, 8'd1);
    // corners, center, outside the grid and extreme coordinates
    for (int i = 0; i < 8; i++) begin
      pt.x = edges[i];
      pt.y = edges[(i + 3) % 8];
      pt.z = edges[(i + 5) % 8];
      send_point(2'(i), pt);
      pt.y = edges[i];
      pt.z = edges[i];
      send_point(2'(3 - i % 4), pt);
    end
    pt.x = 32'sh4000; pt.y = 32'sh8000; pt.z = 32'shC000;
    send_point(2'd0, pt);
    // zero steps returns the point as it came
    write_reg(REG_STEPS, 8'd0);
    send_point(2'd1, pt);
    pt.x = 32'sh80000000;
    send_point(2'd2, pt);
  endtask

  task automatic test_register_extremes();
    // zero and oversize grid values, unused register index
    set_grid(8'd0, 8'hFF, 8'd5, 8'd2);
    write_reg(REG_BAD, 8'h5A);
    send_random(5, 0);
    set_grid(8'd7, 8'd0, 8'd6, 8'd1);
    send_random(5, 0);
  endtask

  task automatic test_long_runs();
    point_t pt;
    set_grid(8'd1, 8'd2, 8'd1, 8'd255);
    for (int i = 0; i < 3; i++) begin
      pt.x = coord(1); pt.y = coord(2); pt.z = coord(1);
      send_point(2'(i % 2), pt);
    end
  endtask

  task automatic test_random_grids();
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      set_grid((ph % 4 == 0) ? 8'd2 : 8'd1, (ph % 4 == 1) ? 8'd2 : 8'd1,
               (ph % 4 == 2) ? 8'd2 : 8'd1, 8'($urandom_range(1, 4)));
      send_random(14, 1);
      // hold the sender until every point is back
      wait_drained();
      send_random(10, 1);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_grid();
    point_t pt;
    // batch 3 in the largest grid, one point in the last cell
    set_grid(8'd4, 8'd4, 8'd4, 8'd2);
    pt.x = 32'shE800; pt.y = 32'shD000; pt.z = 32'shF000;
    send_point(2'd3, pt);
    for (int i = 0; i < 3; i++) begin
      pt.x = coord(4); pt.y = coord(4); pt.z = coord(4);
      send_point(2'd3, pt);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        stall_left <= draw_gap();
        out_ready  <= 1'b0;
      end
    end else if (stall_left <= 0) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Compare each point with the oldest expected one
  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst && out_valid && out_ready) begin
      points_checked++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR: unexpected point %h %h %h", out_x, out_y, out_z);
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_x !== exp_pt.x || out_y !== exp_pt.y || out_z !== exp_pt.z) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("ERROR: point %0d expected %h %h %h got %h %h %h", points_checked,
                     exp_pt.x, exp_pt.y, exp_pt.z, out_x, out_y, out_z);
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("ERROR: no handshake for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_WRITE;
    table_addr = '0;
    table_word = '0;
    batch = '0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    mismatches = 0;
    points_sent = 0;
    writes_sent = 0;
    points_checked = 0;
    quiet_cycles = 0;
    steps_reg = 8'd1;
    gx_reg = 3'd1;
    gy_reg = 3'd1;
    gz_reg = 3'd1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      matrix_mem[i] = '0;
      written_mem[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_long_runs();
    test_random_grids();
    test_full_grid();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d points and %0d table writes over grids up to 4x4x4,", points_sent,
             writes_sent);
    $display("zero to 255 steps, all batches; %0d points checked, %0d mismatches.",
             points_checked, mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== piecewise_affine_point_integrator.f =====
sv/pai_pkg.sv
sv/pai_cell.sv
sv/piecewise_affine_point_integrator.sv
tb/sv/tb.sv
